FILE: rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpl check failed");

// delayed implication, disabled while reset is low
`define BPL_ASSERT_DLY2(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("bpl latency check failed");

`endif

FILE: rtl/core/bpl_pkg.sv
// shared types and codes for the bounded positional list
`default_nettype none
package bpl_pkg;

    // field widths
    localparam int ACT_W  = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 3;
    localparam int LEN_W  = 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    // per-cycle command broadcast to every cell, already qualified by status
    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
    } t_cell_op;

endpackage
`default_nettype wire

FILE: rtl/core/bpl_cell.sv
// one list slot: holds an entry, shifts with its neighbors, compares for find
`default_nettype none
module bpl_cell
    import bpl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  wire logic              i_clk,
    input  wire t_cell_op          i_op,
    input  wire logic [CW-1:0]     i_pos,
    input  wire logic [CW-1:0]     i_cnt,
    input  wire logic [VAL_W-1:0]  i_val,
    input  wire logic [VAL_W-1:0]  i_left,
    input  wire logic [VAL_W-1:0]  i_right,
    output logic      [VAL_W-1:0]  o_data,
    output logic                   o_match
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    // insert opens a gap, delete closes one, update overwrites
    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_val;
            end else if (MY_IDX > i_pos) begin
                n_data = i_left;
            end
        end
        if (i_op.del && (MY_IDX >= i_pos)) begin
            n_data = i_right;
        end
        if (i_op.upd && (MY_IDX == i_pos)) begin
            n_data = i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // only live slots take part in a search
    assign o_match = (MY_IDX < i_cnt) && (r_data == i_val);
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: rtl/core/bpl_first.sv
// first-match encoder over the cell match flags
`default_nettype none
module bpl_first #(
    parameter int N  = 8,
    parameter int IW = 3
) (
    input  wire logic [N-1:0]  i_match,
    output logic               o_any,
    output logic [IW-1:0]      o_idx
);

    logic [N-1:0] w_low;

    // isolate the lowest set bit
    assign w_low = i_match & (~i_match + N'(1));
    assign o_any = |i_match;

    // encode the one-hot flag
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (w_low[i]) begin
                o_idx = o_idx | IW'(i);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bounded_positional_list.sv
// top level of the bounded positional list: command stage, cell row, result stage
//
//   channel   dir  handshake          fields
//   command   in   i_start / o_busy   i_action, i_position, i_value
//   result    out  o_strobe           o_status, o_read_value, o_found_position,
//                                     o_length_now
//
// one command is taken every cycle; o_busy stays low
// the command is registered in the command stage, then the result and its strobe in
//   the result stage, one result per command
// the cell row updates all slots in the cycle after acceptance, so each
//   command sees every earlier one
// synchronous reset empties the list; slot contents are not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
`default_nettype none
module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [VAL_W-1:0]  i_value,
    output logic                          o_strobe,
    output logic [ST_W-1:0]               o_status,
    output logic signed [VAL_W-1:0]       o_read_value,
    output logic [FPOS_W-1:0]             o_found_position,
    output logic [LEN_W-1:0]              o_length_now
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // command stage
    logic              r_go;
    logic [ACT_W-1:0]  r_act;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;

    // list length
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    // result stage
    logic              r_strobe;
    logic [ST_W-1:0]   r_status;
    logic [VAL_W-1:0]  r_rd;
    logic [FPOS_W-1:0] r_fpos;
    logic [LEN_W-1:0]  r_len;

    logic [ST_W-1:0]   n_status;
    logic [VAL_W-1:0]  n_rd;
    logic [FPOS_W-1:0] n_fpos;
    t_cell_op          w_op;

    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_cnt;
    logic [VAL_W-1:0]  w_data  [CAPACITY];
    logic [VAL_W-1:0]  w_left  [CAPACITY];
    logic [VAL_W-1:0]  w_right [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic              w_any;
    logic [IDX_W-1:0]  w_first;
    logic [VAL_W-1:0]  w_sel;

    assign o_busy = 1'b0;
    assign w_pos  = CW'(r_pos);
    assign w_cnt  = CW'(r_cnt);

    // command capture on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= i_action;
        r_pos <= i_position;
        r_val <= i_value;
    end

    // row of slots, neighbors wired left and right
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = r_val;
        end else begin : g_mid
            assign w_left[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = w_data[g];
        end else begin : g_inner
            assign w_right[g] = w_data[g+1];
        end

        bpl_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_cnt   (w_cnt),
            .i_val   (r_val),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    bpl_first #(
        .N  (CAPACITY),
        .IW (IDX_W)
    ) u_first (
        .i_match (w_match),
        .o_any   (w_any),
        .o_idx   (w_first)
    );

    // and-or read select over the row
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == w_pos) begin
                w_sel = w_sel | w_data[i];
            end
        end
    end

    // status, slot command and next length
    always_comb begin
        n_status = ST_OK;
        n_rd     = '0;
        n_fpos   = '0;
        n_cnt    = r_cnt;
        w_op     = '0;
        if (r_go) begin
            case (r_act)
                ACT_INSERT: begin
                    if (w_cnt >= CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else if (w_pos > w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_op.ins = 1'b1;
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                end
                ACT_DELETE: begin
                    if (r_cnt == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_pos >= w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_op.del = 1'b1;
                        n_cnt    = r_cnt - CNT_W'(1);
                    end
                end
                ACT_FIND: begin
                    if (w_any) begin
                        n_fpos = FPOS_W'(w_first);
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                ACT_READ: begin
                    if (w_pos >= w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_rd = w_sel;
                    end
                end
                ACT_UPDATE: begin
                    if (w_pos >= w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_op.upd = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    n_cnt = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // length and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
        r_len    <= LEN_W'(n_cnt);
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_read_value     = $signed(r_rd);
    assign o_found_position = r_fpos;
    assign o_length_now     = r_len;

endmodule
`default_nettype wire

FILE: rtl/core/bpl_checker.sv
// port-level checks for the bounded positional list, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bpl_checker
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_start,
    input wire logic                     o_busy,
    input wire logic                     o_strobe,
    input wire logic [ST_W-1:0]          o_status,
    input wire logic signed [VAL_W-1:0]  o_read_value,
    input wire logic [FPOS_W-1:0]        o_found_position,
    input wire logic [LEN_W-1:0]         o_length_now
);

    // every transfer yields a result strobe after the command and result stages
    `BPL_ASSERT_DLY2(a_latency, i_start && !o_busy, o_strobe)

    // no result without a transfer through the command and result stages
    `BPL_ASSERT_IMP(a_no_spurious, o_strobe, $past(i_start && !o_busy, 2))

    // a full refusal reports a full list
    `BPL_ASSERT_IMP(a_full_len, o_strobe && (o_status == ST_FULL),
        o_length_now == LEN_W'(CAPACITY))

    // an empty refusal reports a zero length
    `BPL_ASSERT_IMP(a_empty_len, o_strobe && (o_status == ST_EMPTY), o_length_now == '0)

    // read data and match position only come with an ok status
    `BPL_ASSERT_IMP(a_payload_ok,
        o_strobe && ((o_read_value != '0) || (o_found_position != '0)), o_status == ST_OK)

endmodule

bind bounded_positional_list bpl_checker #(
    .CAPACITY (CAPACITY)
) u_bpl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_strobe         (o_strobe),
    .o_status         (o_status),
    .o_read_value     (o_read_value),
    .o_found_position (o_found_position),
    .o_length_now     (o_length_now)
);
`default_nettype wire
